### hw/rtl/leb_pkg.sv
// Shared constants, command codes, types and helpers for the line edit buffer.
// No dependencies; imported by leb_csr, leb_core and line_edit_buffer.
package leb_pkg;

   // Character store depth (entries)
   localparam int BUF_DEPTH = 256;
   localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   // Field widths
   localparam int CMD_W  = 4;
   localparam int CHAR_W = 7;
   localparam int IDX_W  = 8;

   // Largest text the store can ever hold
   localparam logic [IDX_W-1:0] LIMIT_MAX = IDX_W'((BUF_DEPTH < 255) ? BUF_DEPTH : 255);

   // Highest non-printable character code
   localparam logic [CHAR_W-1:0] CTRL_MAX = CHAR_W'(31);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CHAR      = 4'd0;
   localparam logic [CMD_W-1:0] CMD_BACKSPACE = 4'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE    = 4'd2;
   localparam logic [CMD_W-1:0] CMD_LEFT      = 4'd3;
   localparam logic [CMD_W-1:0] CMD_RIGHT     = 4'd4;
   localparam logic [CMD_W-1:0] CMD_HOME      = 4'd5;
   localparam logic [CMD_W-1:0] CMD_END       = 4'd6;
   localparam logic [CMD_W-1:0] CMD_ENTER     = 4'd7;
   localparam logic [CMD_W-1:0] CMD_RESET     = 4'd8;

   // Register byte offsets
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_CAPACITY = 3'd0;

   typedef struct packed {
      logic              active;
      logic [IDX_W-1:0]  text_length;
      logic [IDX_W-1:0]  cursor_index;
      logic [CHAR_W-1:0] read_char;
   } result_type;

   // 8-bit text position to store address (truncate or zero-extend)
   function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] v);
      logic [ADDR_W+IDX_W-1:0] t;
      t = {{ADDR_W{1'b0}}, v};
      return t[ADDR_W-1:0];
   endfunction

endpackage

### hw/rtl/leb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module leb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/leb_csr.sv
// APB-style register port holding the capacity register.
// Depends on leb_pkg.
module leb_csr
   import leb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output logic [IDX_W-1:0]      capacity
);

   logic [IDX_W-1:0] cap_ff, cap_in;
   logic             hit;

   // word index 0 is the only register; byte lanes ignored
   assign hit = (paddr[CSR_ADDR_W-1:2] == CSR_CAPACITY[CSR_ADDR_W-1:2]);

   always_comb begin
      cap_in = cap_ff;
      if (psel && penable && pwrite && hit) begin
         cap_in = pwdata[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= IDX_W'(255);
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign prdata   = hit ? {{(32-IDX_W){1'b0}}, cap_ff} : 32'd0;
   assign pready   = 1'b1;
   assign capacity = cap_ff;

endmodule

### hw/rtl/leb_core.sv
// Edit sequencer: decodes a key request, shifts the store one entry a cycle
// through a shared address stepper, then reads back one character. Uses leb_pkg, leb_ram.
module leb_core
   import leb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [IDX_W-1:0]  capacity,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [CHAR_W-1:0] req_char,
   input  logic [IDX_W-1:0]  req_index,
   output logic              result_valid,
   input  logic              result_ready,
   output result_type        result
);

   typedef enum logic [2:0] {
      S_IDLE, S_SHIFT, S_FLUSH, S_PUT, S_READ, S_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic              act_ff, act_in;
   logic [IDX_W-1:0]  len_ff, len_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  ridx_ff, ridx_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic [ADDR_W-1:0] put_ff, put_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [ADDR_W-1:0] stop_ff, stop_in;
   logic [ADDR_W-1:0] waddr_ff, waddr_in;
   logic              wpend_ff, wpend_in;
   logic              right_ff, right_in;   // 1: insert shift, walks down
   logic              ins_ff, ins_in;       // a character is put after the shift

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CHAR_W-1:0] wr_data, rd_data;
   logic [IDX_W-1:0]  limit;
   logic [IDX_W-1:0]  pos;
   logic              do_remove;
   logic [ADDR_W-1:0] step_fwd, step_back;

   leb_ram #(.WIDTH(CHAR_W), .DEPTH(BUF_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // capacity clamped to 1 .. LIMIT_MAX
   always_comb begin
      limit = (capacity == '0) ? IDX_W'(1) : capacity;
      if (limit > LIMIT_MAX) begin
         limit = LIMIT_MAX;
      end
   end

   // shared stepper
   assign step_fwd  = ptr_ff + ADDR_W'(1);
   assign step_back = ptr_ff - ADDR_W'(1);

   assign req_ready    = (state_ff == S_IDLE);
   assign result_valid = (state_ff == S_RESP);
   assign result.active       = act_ff;
   assign result.text_length  = len_ff;
   assign result.cursor_index = cur_ff;
   assign result.read_char    = (ridx_ff < len_ff) ? rd_data : '0;

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      len_in    = len_ff;
      cur_in    = cur_ff;
      ridx_in   = ridx_ff;
      ch_in     = ch_ff;
      put_in    = put_ff;
      ptr_in    = ptr_ff;
      stop_in   = stop_ff;
      waddr_in  = waddr_ff;
      wpend_in  = wpend_ff;
      right_in  = right_ff;
      ins_in    = ins_ff;
      wr_en     = 1'b0;
      wr_addr   = waddr_ff;
      wr_data   = rd_data;
      rd_addr   = ptr_ff;
      pos       = cur_ff;
      do_remove = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ridx_in  = req_index;
               ch_in    = req_char;
               wpend_in = 1'b0;
               ins_in   = 1'b0;
               state_in = S_READ;
               case (req_cmd)
                  CMD_CHAR: begin
                     if (req_char > CTRL_MAX) begin
                        if (len_ff >= limit) begin
                           // full: overwrite the last character (limit >= 1, so len >= 1)
                           wr_en   = 1'b1;
                           wr_addr = to_addr(len_ff - IDX_W'(1));
                           wr_data = req_char;
                        end else begin
                           put_in   = to_addr(cur_ff);
                           ins_in   = 1'b1;
                           len_in   = len_ff + IDX_W'(1);
                           cur_in   = cur_ff + IDX_W'(1);
                           right_in = 1'b1;
                           ptr_in   = to_addr(len_ff - IDX_W'(1));
                           stop_in  = to_addr(cur_ff);
                           state_in = (len_ff > cur_ff) ? S_SHIFT : S_PUT;
                        end
                     end
                  end
                  CMD_BACKSPACE: begin
                     if (cur_ff != '0) begin
                        pos       = cur_ff - IDX_W'(1);
                        cur_in    = pos;
                        do_remove = 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     if (cur_ff < len_ff) begin
                        pos       = cur_ff;
                        do_remove = 1'b1;
                     end
                  end
                  CMD_LEFT: begin
                     if (cur_ff != '0) begin
                        cur_in = cur_ff - IDX_W'(1);
                     end
                  end
                  CMD_RIGHT: begin
                     if (cur_ff < len_ff) begin
                        cur_in = cur_ff + IDX_W'(1);
                     end
                  end
                  CMD_HOME:  cur_in = '0;
                  CMD_END:   cur_in = len_ff;
                  CMD_ENTER: act_in = 1'b0;
                  CMD_RESET: begin
                     // entries past the text are never reported, so no clearing
                     len_in = '0;
                     cur_in = '0;
                     act_in = 1'b1;
                  end
                  default: ;
               endcase
               if (do_remove) begin
                  len_in   = len_ff - IDX_W'(1);
                  right_in = 1'b0;
                  ptr_in   = to_addr(pos + IDX_W'(1));
                  stop_in  = to_addr(len_ff - IDX_W'(1));
                  if ((pos + IDX_W'(1)) < len_ff) begin
                     state_in = S_SHIFT;
                  end
               end
            end
         end
         S_SHIFT: begin
            // read ptr now, write its data one place over next cycle
            rd_addr  = ptr_ff;
            wr_en    = wpend_ff;
            wpend_in = 1'b1;
            waddr_in = right_ff ? step_fwd : step_back;
            if (ptr_ff == stop_ff) begin
               state_in = S_FLUSH;
            end else begin
               ptr_in = right_ff ? step_back : step_fwd;
            end
         end
         S_FLUSH: begin
            wr_en    = 1'b1;
            wpend_in = 1'b0;
            state_in = ins_ff ? S_PUT : S_READ;
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = put_ff;
            wr_data  = ch_ff;
            state_in = S_READ;
         end
         S_READ: begin
            rd_addr  = to_addr(ridx_ff);
            state_in = S_RESP;
         end
         S_RESP: begin
            // hold the read address so the read data stays put
            rd_addr = to_addr(ridx_ff);
            if (result_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         act_ff   <= 1'b1;
         len_ff   <= '0;
         cur_ff   <= '0;
         wpend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
         len_ff   <= len_in;
         cur_ff   <= cur_in;
         wpend_ff <= wpend_in;
      end
      ridx_ff  <= ridx_in;
      ch_ff    <= ch_in;
      put_ff   <= put_in;
      ptr_ff   <= ptr_in;
      stop_ff  <= stop_in;
      waddr_ff <= waddr_in;
      right_ff <= right_in;
      ins_ff   <= ins_in;
   end

endmodule

### hw/rtl/line_edit_buffer.sv
// Line edit buffer top level: register port, edit sequencer and result register.
// Depends on leb_pkg, leb_csr, leb_core.
//
// Usage:
//  - req_ carries one key request: tuser is the command, tdata the character
//    and the read index. rsp_ returns one result per request: active flag,
//    text length, cursor and the character at the read index (0 past the text).
//  - After acceptance the sequencer moves one entry per step for insert,
//    backspace or delete, flushes the tail when any entry moves, puts the
//    character on insert, then reads back the character at the read index.
//    Shifting is bound by the single write port of the character store,
//    stepped one address a cycle by a shared stepper.
//  - req_tready is high only while the sequencer is idle: one request at a time.
//  - Results pass through an output register, so the next request is accepted
//    while a result waits; a stalled receiver holds rsp_ steady and the next
//    result waits in the sequencer until the register frees.
//  - Reset empties the text, zeroes the cursor, sets active and loads capacity
//    with 255. No clearing pass is needed: stale store entries sit past the text.
//  - capacity is written over csr_ at byte address 0; the user must write it only while idle (not enforced).
module line_edit_buffer
   import leb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request: tuser = cmd[3:0]
   //          tdata = key_char[6:0], read_index[14:7], zero[15]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,
   input  logic [CMD_W-1:0]      req_tuser,
   // response: tdata = active[0], text_length[8:1], cursor_index[16:9],
   //                   read_char[23:17]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [IDX_W-1:0] capacity;
   logic             result_valid;
   logic             result_ready;
   result_type       result;

   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff, rsp_data_in;

   leb_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready),
      .capacity (capacity)
   );

   leb_core u_core (
      .clock        (clock),
      .reset        (reset),
      .capacity     (capacity),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_cmd      (req_tuser),
      .req_char     (req_tdata[6:0]),
      .req_index    (req_tdata[14:7]),
      .result_valid (result_valid),
      .result_ready (result_ready),
      .result       (result)
   );

   // register frees when empty or being taken this cycle
   assign result_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (result_valid && result_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.read_char, rsp_data_ff.cursor_index,
                        rsp_data_ff.text_length, rsp_data_ff.active};

endmodule
